/* hw/rtl/bitmap_slot_allocator_macros.svh */
// Assertion macros for the bitmap slot allocator checker.
// Needs signals named clk and rst in the scope where the macros are used.
`ifndef BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bitmap_slot_allocator: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bitmap_slot_allocator: next-cycle check failed");

`endif

/* hw/rtl/bsa_pkg.sv */
// Shared types and constants of the bitmap slot allocator.
// No dependencies; used by bsa_cell, bitmap_slot_allocator and bsa_checker.
`default_nettype none

package bsa_pkg;

  localparam int SLOTS     = 64;
  localparam int CELL_BITS = 8;
  localparam int CELL_LOG  = $clog2(CELL_BITS);
  localparam int CELLS     = (SLOTS + CELL_BITS - 1) / CELL_BITS;
  localparam int CIDX_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int HIT_W     = CIDX_W + CELL_LOG;
  localparam int CNT_W     = 7;
  localparam int POS_W     = CNT_W + 1;
  localparam int ADDR_W    = 32;
  localparam int SH_W      = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [2:0] MODE_ALLOC   = 3'd0;
  localparam logic [2:0] MODE_RELEASE = 3'd1;
  localparam logic [2:0] MODE_RESET   = 3'd2;
  localparam logic [2:0] MODE_QUERY   = 3'd3;
  localparam logic [2:0] MODE_NEXT    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OBJECTS  = 2'd2;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_FULL,
    ERR_OUTSIDE,
    ERR_MISALIGNED,
    ERR_NOT_ALLOC
  } bsa_err_t;

  // Search packet walking down the row of cells.
  typedef struct packed {
    logic             valid;
    logic             alloc;  // 1: look for a free slot and take it; 0: next alive
    logic             found;
    logic [HIT_W-1:0] hit;
  } bsa_scan_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic             clear_all;
    logic             clear_en;
    logic [HIT_W-1:0] clear_slot;
    logic [POS_W-1:0] scan_from;
    logic [CNT_W-1:0] scan_lim;
  } bsa_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/bsa_cell.sv */
// One cell of the allocator row: holds CELL_BITS alive bits and passes the
// search packet to its neighbor. Depends on bsa_pkg.
`default_nettype none

module bsa_cell
  import bsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CIDX_W-1:0]    cell_idx,
  input  bsa_ctl_t             ctl,
  input  bsa_scan_t            scan_in,
  output bsa_scan_t            scan_out,
  output logic [CELL_BITS-1:0] bits
);

  logic [CELL_BITS-1:0] eligible;
  logic                 hit_any;
  logic [CELL_LOG-1:0]  hit_j;
  logic                 take;

  always_comb begin
    logic [POS_W-1:0] pos;
    eligible = '0;
    hit_any  = 1'b0;
    hit_j    = '0;
    for (int j = 0; j < CELL_BITS; j++) begin
      pos = (POS_W'(cell_idx) << CELL_LOG) | POS_W'(j);
      eligible[j] = (pos >= ctl.scan_from) && (pos < POS_W'(ctl.scan_lim))
                    && (bits[j] ^ scan_in.alloc);
    end
    // lowest eligible position wins
    for (int j = CELL_BITS - 1; j >= 0; j--) begin
      if (eligible[j]) begin
        hit_any = 1'b1;
        hit_j   = CELL_LOG'(j);
      end
    end
  end

  assign take = scan_in.valid && !scan_in.found && hit_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits     <= '0;
      scan_out <= '0;
    end else begin
      scan_out <= scan_in;
      if (take) begin
        scan_out.found <= 1'b1;
        scan_out.hit   <= {cell_idx, hit_j};
      end
      if (ctl.clear_all) begin
        bits <= '0;
      end else begin
        if (ctl.clear_en && (ctl.clear_slot[HIT_W-1:CELL_LOG] == cell_idx)) begin
          bits[ctl.clear_slot[CELL_LOG-1:0]] <= 1'b0;
        end
        if (take && scan_in.alloc) begin
          bits[hit_j] <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bitmap_slot_allocator.sv */
// Top level of the bitmap slot allocator: sequencer, configuration registers
// and the row of bsa_cell instances. Depends on bsa_pkg and bsa_cell.
//
// Usage: raise start with mode, address and slot; the item is taken at a
// rising edge where busy is low. Each item gives exactly one result, shown
// for one cycle with done high together with ok, error_code, result_address,
// result_slot, alive and allocated_count. The receiver cannot stall: a result
// not taken in its cycle is gone.
// Steps from accept to the done cycle: query, reset and unknown modes register
// the result at accept; release forms the address offset, then shifts,
// compares and clears; allocate and next load the search packet, let it walk
// the row of 8 cells, one cell of 8 slots per cycle, and register the result.
// A full pool answers allocate without a scan.
// One item at a time: a new item can be taken in the cycle done is shown, so
// query, reset, unknown modes and a refused allocate can follow every cycle.
// Configuration is written through wr_en, wr_index and wr_data; the user must
// write only while idle; the block has no check. Reset clears all alive bits and
// the count and loads base_address 0, object_size_log2 2 and max_objects 64.
`default_nettype none

module bitmap_slot_allocator
  import bsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           mode,
  input  logic [ADDR_W-1:0]    address,
  input  logic [CNT_W-1:0]     slot,
  output logic                 done,
  output logic                 ok,
  output logic [2:0]           error_code,
  output logic [ADDR_W-1:0]    result_address,
  output logic [CNT_W-1:0]     result_slot,
  output logic                 alive,
  output logic [CNT_W-1:0]     allocated_count,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [ADDR_W-1:0]    wr_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_REL} state_t;

  state_t                   state;
  logic [ADDR_W-1:0]        base_address;
  logic [SH_W-1:0]          object_size_log2;
  logic [CNT_W-1:0]         max_objects;
  logic [CNT_W-1:0]         used_count;
  logic [CNT_W-1:0]         op_lim;
  logic [POS_W-1:0]         op_from;
  logic [ADDR_W-1:0]        offset;
  bsa_scan_t                inject;
  bsa_scan_t                chain [CELLS+1];
  logic [CELLS*CELL_BITS-1:0] all_bits;
  bsa_ctl_t                 ctl;

  logic [CNT_W-1:0]  lim;
  logic [ADDR_W-1:0] rel_id;
  logic              rel_outside;
  logic              rel_misaligned;
  logic              rel_free;
  logic              accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign lim    = (max_objects > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : max_objects;

  assign rel_id         = offset >> object_size_log2;
  assign rel_outside    = rel_id >= ADDR_W'(op_lim);
  assign rel_misaligned = (offset & ~({ADDR_W{1'b1}} << object_size_log2)) != '0;
  assign rel_free       = !all_bits[rel_id[HIT_W-1:0]];

  always_comb begin
    ctl            = '0;
    ctl.clear_all  = accept && (mode == MODE_RESET);
    ctl.clear_en   = (state == ST_REL) && !rel_outside && !rel_misaligned && !rel_free;
    ctl.clear_slot = rel_id[HIT_W-1:0];
    ctl.scan_from  = op_from;
    ctl.scan_lim   = op_lim;
  end

  assign chain[0] = inject;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    bsa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (CIDX_W'(k)),
      .ctl      (ctl),
      .scan_in  (chain[k]),
      .scan_out (chain[k+1]),
      .bits     (all_bits[k*CELL_BITS +: CELL_BITS])
    );
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address     <= '0;
      object_size_log2 <= SH_W'(2);
      max_objects      <= CNT_W'(SLOTS);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BASE_ADDRESS: base_address     <= wr_data;
        REG_SIZE_LOG2:    object_size_log2 <= wr_data[SH_W-1:0];
        REG_MAX_OBJECTS:  max_objects      <= wr_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      inject     <= '0;
      used_count <= '0;
    end else begin
      done         <= 1'b0;
      inject.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op_lim          <= lim;
            ok              <= 1'b0;
            error_code      <= ERR_NONE;
            result_address  <= '0;
            result_slot     <= '0;
            alive           <= 1'b0;
            allocated_count <= used_count;
            unique case (mode)
              MODE_ALLOC: begin
                if (used_count >= lim) begin
                  done       <= 1'b1;
                  error_code <= ERR_FULL;
                end else begin
                  inject  <= '{valid: 1'b1, alloc: 1'b1, found: 1'b0, hit: '0};
                  op_from <= '0;
                  state   <= ST_SCAN;
                end
              end
              MODE_RELEASE: begin
                offset <= address - base_address;
                state  <= ST_REL;
              end
              MODE_RESET: begin
                used_count      <= '0;
                allocated_count <= '0;
                ok              <= 1'b1;
                done            <= 1'b1;
              end
              MODE_QUERY: begin
                done        <= 1'b1;
                result_slot <= slot;
                if (slot >= lim) begin
                  error_code <= ERR_OUTSIDE;
                end else begin
                  ok    <= 1'b1;
                  alive <= all_bits[slot[HIT_W-1:0]];
                end
              end
              MODE_NEXT: begin
                inject  <= '{valid: 1'b1, alloc: 1'b0, found: 1'b0, hit: '0};
                op_from <= POS_W'(slot) + POS_W'(1);
                state   <= ST_SCAN;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (chain[CELLS].valid) begin
            state <= ST_IDLE;
            done  <= 1'b1;
            if (chain[CELLS].alloc) begin
              if (chain[CELLS].found) begin
                ok              <= 1'b1;
                result_address  <= base_address
                                   + (ADDR_W'(chain[CELLS].hit) << object_size_log2);
                result_slot     <= CNT_W'(chain[CELLS].hit);
                used_count      <= used_count + CNT_W'(1);
                allocated_count <= used_count + CNT_W'(1);
              end else begin
                error_code <= ERR_FULL;
              end
            end else begin
              ok          <= 1'b1;
              result_slot <= chain[CELLS].found ? CNT_W'(chain[CELLS].hit) : op_lim;
            end
          end
        end
        ST_REL: begin
          state <= ST_IDLE;
          done  <= 1'b1;
          priority if (rel_outside) begin
            error_code <= ERR_OUTSIDE;
          end else if (rel_misaligned) begin
            error_code <= ERR_MISALIGNED;
          end else if (rel_free) begin
            error_code  <= ERR_NOT_ALLOC;
            result_slot <= rel_id[CNT_W-1:0];
          end else begin
            ok          <= 1'b1;
            result_slot <= rel_id[CNT_W-1:0];
            if (used_count != '0) begin
              used_count      <= used_count - CNT_W'(1);
              allocated_count <= used_count - CNT_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bsa_checker.sv */
// Port-level checks of the bitmap slot allocator and the bind that attaches
// them. Depends on bsa_pkg and bitmap_slot_allocator_macros.svh.
`default_nettype none
`include "bitmap_slot_allocator_macros.svh"

module bsa_checker
  import bsa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic              ok,
  input logic [2:0]        error_code,
  input logic [ADDR_W-1:0] result_address,
  input logic              alive,
  input logic [CNT_W-1:0]  allocated_count
);

  // every accepted item is either answered at once or keeps the block busy
  `BSA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)
  // success never carries an error code
  `BSA_ASSERT_NOW(a_ok_no_error, done && ok, error_code == ERR_NONE)
  // failed items report no address and no alive bit
  `BSA_ASSERT_NOW(a_fail_clean, done && !ok, result_address == '0 && !alive)
  // the count can never exceed the pool
  `BSA_ASSERT_NOW(a_count_bound, done, allocated_count <= CNT_W'(SLOTS))

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .ok              (ok),
  .error_code      (error_code),
  .result_address  (result_address),
  .alive           (alive),
  .allocated_count (allocated_count)
);

`default_nettype wire
